FILE: rtl/sscp_pkg.sv
// Package: command codes, run phases, payload structs and constants for the S-curve stepper.
package sscp_pkg;

  typedef enum logic [2:0] {
    FUNC_TICK     = 3'd0,
    FUNC_MOVE     = 3'd1,
    FUNC_MOVE_MM  = 3'd2,
    FUNC_HOME     = 3'd3,
    FUNC_STOP     = 3'd4,
    FUNC_RUN      = 3'd5,
    FUNC_LOAD     = 3'd6,
    FUNC_NOP      = 3'd7
  } func_t;

  typedef enum logic [1:0] {
    PH_STOPPED = 2'd0,
    PH_ACCEL   = 2'd1,
    PH_CRUISE  = 2'd2,
    PH_DECEL   = 2'd3
  } phase_t;

  localparam logic [2:0] CFG_ACCUM_THR  = 3'd0;
  localparam logic [2:0] CFG_STEPS_MM   = 3'd1;
  localparam logic [2:0] CFG_STEPS_REV  = 3'd2;
  localparam logic [2:0] CFG_HOME_LEVEL = 3'd3;
  localparam logic [2:0] CFG_HOME_DIR   = 3'd4;

  localparam logic [15:0] PEAK_OFFSET = 16'd100;   // added to requested top speed
  localparam logic [31:0] HOME_REVS   = 32'd1000;  // homing run length, revolutions
  localparam logic [31:0] RUN_REVS    = 32'd100;   // continuous run length, revolutions

  typedef struct packed {
    logic [2:0]         func;
    logic signed [31:0] move_steps;
    logic [15:0]        target_mm;
    logic [15:0]        top_speed;
    logic [15:0]        ramp_interval;
    logic               run_forward;
    logic               home_sensor;
    logic [7:0]         curve_index;
    logic [15:0]        curve_value;
  } in_t;

  typedef struct packed {
    logic               step_pulse;
    logic               dir_level;
    logic signed [31:0] abs_position;
    logic [1:0]         phase;
  } out_t;

endpackage

FILE: rtl/sscp_curve_lut.sv
// Curve table memory with registered read and peak-speed scaling multiplier.
module sscp_curve_lut
  import sscp_pkg::*;
#(
  parameter int AW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [15:0]   wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  input  logic [15:0]   peak,
  output logic          busy,
  output logic          spd_valid,
  output logic [15:0]   spd
);

  logic [15:0] mem [2**AW];
  logic [15:0] rdata_r;
  logic [31:0] prod_r;
  logic        rd_pend_r;
  logic        mul_pend_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // product registered before it reaches the speed register
  always_ff @(posedge clk) begin
    if (rd_pend_r) begin
      prod_r <= rdata_r * peak;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pend_r  <= 1'b0;
      mul_pend_r <= 1'b0;
    end else begin
      rd_pend_r  <= rd_en;
      mul_pend_r <= rd_pend_r;
    end
  end

  assign busy      = rd_pend_r | mul_pend_r;
  assign spd_valid = mul_pend_r;
  assign spd       = prod_r[31:16];

endmodule

FILE: rtl/stepper_s_curve_profile_top.sv
// Top level: S-curve stepper step generator with command decode and curve table control.
// Output: the result of an accepted transfer is on the out_ port in the following cycle (registered).
// Throughput: one transfer per cycle unless the output is stalled; a tick that moves along the
//   curve table holds in_stall while the table read and the speed-scaling multiply complete.
// Reset (rst_n, synchronous, active low): run state, counters and config registers return to
//   their defaults; the curve table memory is not cleared and is undefined until loaded.
module stepper_s_curve_profile_top
  import sscp_pkg::*;
#(
  parameter int CURVE_POINTS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam int AW  = $clog2(CURVE_POINTS);
  localparam int CPW = $clog2(CURVE_POINTS + 1);
  localparam logic [CPW-1:0] CP_END = CPW'(CURVE_POINTS);

  // configuration registers
  logic [15:0] accum_thr_r;
  logic [14:0] steps_mm_r;
  logic [15:0] steps_rev_r;
  logic        home_level_r;
  logic        home_dir_r;

  // run state
  phase_t             phase_r, phase_nxt;
  logic signed [31:0] goal_r, goal_nxt;
  logic [31:0]        done_r, done_nxt;
  logic signed [31:0] pos_r, pos_nxt;
  logic [15:0]        speed_r, speed_nxt;
  logic [15:0]        peak_r, peak_nxt;
  logic [16:0]        accum_r, accum_nxt;
  logic [15:0]        tcount_r, tcount_nxt;
  logic [15:0]        ivl_r, ivl_nxt;
  logic [CPW-1:0]     cpos_r, cpos_nxt;
  logic [31:0]        ramp_steps_r, ramp_steps_nxt;
  logic               ramp_on_r, ramp_on_nxt;
  logic               homing_r, homing_nxt;
  logic               cont_r, cont_nxt;
  logic               dir_r, dir_nxt;

  logic  out_valid_r, out_valid_nxt;
  out_t  out_r, out_nxt;

  logic          accept;
  logic          lut_busy;
  logic          lut_spd_valid;
  logic [15:0]   lut_spd;
  logic          look_en;
  logic [AW-1:0] look_addr;
  logic          load_en;

  assign in_stall = lut_busy | (out_valid_r & out_stall);
  assign accept   = in_valid & ~in_stall;
  assign load_en  = accept && (in_data.func == FUNC_LOAD) &&
                    (32'(in_data.curve_index) < CURVE_POINTS);

  sscp_curve_lut #(.AW(AW)) u_lut (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (load_en),
    .wr_addr   (AW'(in_data.curve_index)),
    .wr_data   (in_data.curve_value),
    .rd_en     (look_en),
    .rd_addr   (look_addr),
    .peak      (peak_r),
    .busy      (lut_busy),
    .spd_valid (lut_spd_valid),
    .spd       (lut_spd)
  );

  // command and tick evaluation
  always_comb begin
    logic signed [31:0] mv;
    logic               do_start;
    logic               carry;
    logic [17:0]        acc;
    logic [31:0]        total;
    logic               pulse;
    logic               look_req;

    phase_nxt      = phase_r;
    goal_nxt       = goal_r;
    done_nxt       = done_r;
    pos_nxt        = pos_r;
    speed_nxt      = speed_r;
    peak_nxt       = peak_r;
    accum_nxt      = accum_r;
    tcount_nxt     = tcount_r;
    ivl_nxt        = ivl_r;
    cpos_nxt       = cpos_r;
    ramp_steps_nxt = ramp_steps_r;
    ramp_on_nxt    = ramp_on_r;
    homing_nxt     = homing_r;
    cont_nxt       = cont_r;
    dir_nxt        = dir_r;
    mv             = in_data.move_steps;
    do_start       = 1'b0;
    carry          = 1'b0;
    acc            = 18'd0;
    total          = 32'd0;
    pulse          = 1'b0;
    look_req       = 1'b0;

    if (!accept && lut_spd_valid) begin
      speed_nxt = lut_spd;
    end

    if (accept) begin
      case (func_t'(in_data.func))
        FUNC_TICK: begin
          if (phase_r != PH_STOPPED) begin
            acc = {1'b0, accum_r} + 18'(speed_r);
            if (acc >= 18'(accum_thr_r)) begin
              carry = 1'b1;
              acc   = acc - 18'(accum_thr_r);
            end
            accum_nxt = acc[16:0];
            if (carry) begin
              done_nxt = done_nxt + 32'd1;
              pos_nxt  = (goal_r > 0) ? pos_nxt + 32'sd1 : pos_nxt - 32'sd1;
              if (in_data.home_sensor == home_level_r) begin
                if (homing_r) begin
                  phase_nxt  = PH_STOPPED;
                  cont_nxt   = 1'b0;
                  homing_nxt = 1'b0;
                  pos_nxt    = 32'sd0;
                end else if (goal_r < 0) begin
                  phase_nxt = PH_STOPPED;
                  cont_nxt  = 1'b0;
                end
              end
            end
            total = (goal_r < 0) ? 32'd0 - 32'(goal_r) : 32'(goal_r);
            case (phase_nxt)
              PH_ACCEL: begin
                if (carry) ramp_steps_nxt = ramp_steps_nxt + 32'd1;
                if (ramp_on_nxt) begin
                  tcount_nxt = tcount_nxt + 16'd1;
                  if (tcount_nxt >= ivl_r) begin
                    tcount_nxt = 16'd0;
                    cpos_nxt   = cpos_nxt + CPW'(1);
                    if (cpos_nxt >= CP_END) begin
                      cpos_nxt    = CP_END;
                      ramp_on_nxt = 1'b0;
                      speed_nxt   = peak_r;
                      phase_nxt   = PH_CRUISE;
                    end else begin
                      look_req = 1'b1;
                    end
                  end
                end
                if (total > 32'd1) begin
                  if (done_nxt >= (total >> 1)) begin
                    tcount_nxt = ivl_r - tcount_nxt;
                    phase_nxt  = PH_DECEL;
                  end
                end else if (done_nxt > 32'd0) begin
                  phase_nxt = PH_DECEL;
                end
              end
              PH_CRUISE: begin
                if (cont_nxt && carry) begin
                  done_nxt = done_nxt - 32'd1;
                  pos_nxt  = (goal_r > 0) ? pos_nxt - 32'sd1 : pos_nxt + 32'sd1;
                end
                if (total - done_nxt <= ramp_steps_nxt) begin
                  ramp_on_nxt = 1'b1;
                  if (cpos_nxt != '0) cpos_nxt = cpos_nxt - CPW'(1);
                  look_req  = 1'b1;
                  phase_nxt = PH_DECEL;
                end
              end
              PH_DECEL: begin
                if (ramp_on_nxt) begin
                  tcount_nxt = tcount_nxt + 16'd1;
                  if (tcount_nxt >= ivl_r) begin
                    tcount_nxt = 16'd0;
                    if (cpos_nxt != '0) cpos_nxt = cpos_nxt - CPW'(1);
                    look_req = 1'b1;
                    if (cpos_nxt <= CPW'(1)) ramp_on_nxt = 1'b0;
                  end
                end
                if (done_nxt >= total) begin
                  phase_nxt = PH_STOPPED;
                  cont_nxt  = 1'b0;
                end
              end
              default: begin
              end
            endcase
            pulse = carry;
          end
        end
        FUNC_MOVE: begin
          do_start = 1'b1;
        end
        FUNC_MOVE_MM: begin
          mv       = 32'(in_data.target_mm) * 32'(steps_mm_r) - pos_r;
          do_start = 1'b1;
        end
        FUNC_HOME: begin
          homing_nxt = 1'b1;
          mv         = 32'd0 - 32'(32'(steps_rev_r) * HOME_REVS);
          do_start   = 1'b1;
        end
        FUNC_STOP: begin
          phase_nxt = PH_STOPPED;
          cont_nxt  = 1'b0;
        end
        FUNC_RUN: begin
          cont_nxt = 1'b1;
          mv       = 32'(32'(steps_rev_r) * RUN_REVS);
          if (!in_data.run_forward) mv = 32'd0 - mv;
          do_start = 1'b1;
        end
        default: begin
        end
      endcase

      if (do_start) begin
        if (mv == 32'sd0) begin
          phase_nxt = PH_STOPPED;
          cont_nxt  = 1'b0;
        end else begin
          goal_nxt  = mv;
          done_nxt  = 32'd0;
          speed_nxt = 16'd0;
          if ($signed({2'b00, in_data.top_speed}) >
              $signed({2'b00, accum_thr_r}) - 18'sd100) begin
            peak_nxt = accum_thr_r;
          end else begin
            peak_nxt = in_data.top_speed + PEAK_OFFSET;
          end
          ramp_on_nxt    = 1'b1;
          tcount_nxt     = 16'd0;
          cpos_nxt       = '0;
          ramp_steps_nxt = 32'd0;
          ivl_nxt        = in_data.ramp_interval;
          accum_nxt      = 17'd0;
          dir_nxt        = (mv > 0) ? ~home_dir_r : home_dir_r;
          phase_nxt      = PH_ACCEL;
        end
      end

      // table entries exist only below CURVE_POINTS; past the end the speed is the peak
      if (look_req) begin
        if (cpos_nxt >= CP_END) begin
          look_req  = 1'b0;
          speed_nxt = peak_r;
        end
      end
    end

    look_en   = look_req;
    look_addr = cpos_nxt[AW-1:0];

    out_nxt.step_pulse   = pulse;
    out_nxt.dir_level    = dir_nxt;
    out_nxt.abs_position = pos_nxt;
    out_nxt.phase        = phase_nxt;
  end

  always_comb begin
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_thr_r  <= 16'd10000;
      steps_mm_r   <= 15'd100;
      steps_rev_r  <= 16'd3200;
      home_level_r <= 1'b0;
      home_dir_r   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ACCUM_THR:  accum_thr_r  <= cfg_wdata;
        CFG_STEPS_MM:   steps_mm_r   <= cfg_wdata[14:0];
        CFG_STEPS_REV:  steps_rev_r  <= cfg_wdata;
        CFG_HOME_LEVEL: home_level_r <= cfg_wdata[0];
        CFG_HOME_DIR:   home_dir_r   <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_STOPPED;
      goal_r       <= 32'sd0;
      done_r       <= 32'd0;
      pos_r        <= 32'sd0;
      speed_r      <= 16'd0;
      peak_r       <= 16'd0;
      accum_r      <= 17'd0;
      tcount_r     <= 16'd0;
      ivl_r        <= 16'd0;
      cpos_r       <= '0;
      ramp_steps_r <= 32'd0;
      ramp_on_r    <= 1'b0;
      homing_r     <= 1'b0;
      cont_r       <= 1'b0;
      dir_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      goal_r       <= goal_nxt;
      done_r       <= done_nxt;
      pos_r        <= pos_nxt;
      speed_r      <= speed_nxt;
      peak_r       <= peak_nxt;
      accum_r      <= accum_nxt;
      tcount_r     <= tcount_nxt;
      ivl_r        <= ivl_nxt;
      cpos_r       <= cpos_nxt;
      ramp_steps_r <= ramp_steps_nxt;
      ramp_on_r    <= ramp_on_nxt;
      homing_r     <= homing_nxt;
      cont_r       <= cont_nxt;
      dir_r        <= dir_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // result register: loaded on each accepted transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  // a table lookup keeps the input closed until the scaled speed lands
  a_look_stall: assert property (@(posedge clk) disable iff (!rst_n)
    look_en |=> in_stall)
    else $error("input not stalled during curve lookup");

  a_cpos_range: assert property (@(posedge clk) disable iff (!rst_n)
    cpos_r <= CP_END)
    else $error("curve position past table end");

  a_no_speed_race: assert property (@(posedge clk) disable iff (!rst_n)
    lut_spd_valid |-> !accept)
    else $error("transfer accepted while speed update pending");
`endif

endmodule

FILE: dv/testbench.sv
// Testbench for the S-curve stepper step generator: random and directed commands, checked per transfer.
`timescale 1ns / 100ps

module testbench;
  import sscp_pkg::*;

  localparam int TABLE_SIZE = 256;
  localparam int NUM_PASSES = 6;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_data;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = CFG_ACCUM_THR;
  logic [15:0] cfg_wdata = '0;

  stepper_s_curve_profile_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  // Commands waiting to be sent, and motor states the block must report.
  in_t  cmd_q[$];
  out_t status_q[$];
  int   mismatches = 0;
  logic took = 1'b0;
  // Traffic shaping: 0 none, 1 sender gaps, 2 receiver stalls, 3 both.
  int   idle_mode = 0;
  // idle percentage per side; lower when both sides idle
  int   idle_pct = 59;

  // ---------------------------------------------------------------
  // Motor model: settings, run state and the curve table.
  // ---------------------------------------------------------------
  int unsigned m_thr, m_spmm, m_sprev, m_home_lvl, m_home_dir;
  int unsigned m_phase, m_done, m_speed, m_peak, m_accum, m_ticks, m_ivl;
  int unsigned m_cpos, m_ramp_steps, m_dir;
  int          m_goal, m_pos;
  bit          m_ramp_on, m_homing, m_cont;
  logic [15:0] m_curve[TABLE_SIZE];

  function automatic int unsigned curve_speed(int unsigned idx);
    if (idx >= TABLE_SIZE) return m_peak;
    return int'((longint'(m_curve[idx]) * longint'(m_peak)) >> 16);
  endfunction

  function automatic void halt_motor();
    m_phase = PH_STOPPED;
    m_cont  = 1'b0;
  endfunction

  function automatic void launch(int steps, int unsigned top, int unsigned ivl);
    if (steps == 0) begin
      halt_motor();
      return;
    end
    m_goal = steps;
    m_done = 0;
    m_speed = 0;
    // peak is top + offset, clamped to the overflow value
    if (int'(top) > int'(m_thr) - 100) m_peak = m_thr;
    else m_peak = top + 100;
    m_ramp_on = 1'b1;
    m_ticks = 0;
    m_cpos = 0;
    m_ramp_steps = 0;
    m_ivl = ivl & 16'hFFFF;
    m_accum = 0;
    m_dir = (steps > 0) ? (m_home_dir ^ 1) : m_home_dir;
    m_phase = PH_ACCEL;
  endfunction

  function automatic void step_pos(bit fwd);
    m_pos = fwd ? m_pos + 1 : m_pos - 1;
  endfunction

  function automatic bit motor_tick(bit sensor);
    bit carry;
    int unsigned total;
    carry = 1'b0;
    if (m_phase == PH_STOPPED) return 1'b0;
    m_accum += m_speed;
    if (m_accum >= m_thr) begin
      carry = 1'b1;
      m_accum -= m_thr;
    end
    m_accum &= 32'h1FFFF;
    if (carry) begin
      m_done++;
      step_pos(m_goal > 0);
      if (sensor == m_home_lvl[0]) begin
        if (m_homing) begin
          halt_motor();
          m_homing = 1'b0;
          m_pos = 0;
        end else if (m_goal < 0) begin
          // switch blocks motion toward home
          halt_motor();
        end
      end
    end
    total = (m_goal < 0) ? 32'd0 - 32'(m_goal) : 32'(m_goal);
    case (m_phase)
      PH_ACCEL: begin
        if (carry) m_ramp_steps++;
        if (m_ramp_on) begin
          m_ticks = (m_ticks + 1) & 16'hFFFF;
          if (m_ticks >= m_ivl) begin
            m_ticks = 0;
            m_cpos++;
            if (m_cpos >= TABLE_SIZE) begin
              m_cpos = TABLE_SIZE;
              m_ramp_on = 1'b0;
              m_speed = m_peak;
              m_phase = PH_CRUISE;
            end else begin
              m_speed = curve_speed(m_cpos);
            end
          end
        end
        if (total > 1) begin
          if (m_done >= total / 2) begin
            m_ticks = (m_ivl - m_ticks) & 16'hFFFF;
            m_phase = PH_DECEL;
          end
        end else if (m_done > 0) begin
          m_phase = PH_DECEL;
        end
      end
      PH_CRUISE: begin
        if (m_cont && carry) begin
          m_done--;
          step_pos(!(m_goal > 0));
        end
        if (total - m_done <= m_ramp_steps) begin
          m_ramp_on = 1'b1;
          if (m_cpos > 0) m_cpos--;
          m_speed = curve_speed(m_cpos);
          m_phase = PH_DECEL;
        end
      end
      PH_DECEL: begin
        if (m_ramp_on) begin
          m_ticks = (m_ticks + 1) & 16'hFFFF;
          if (m_ticks >= m_ivl) begin
            m_ticks = 0;
            if (m_cpos > 0) m_cpos--;
            m_speed = curve_speed(m_cpos);
            if (m_cpos <= 1) m_ramp_on = 1'b0;
          end
        end
        if (m_done >= total) halt_motor();
      end
      default: ;
    endcase
    return carry;
  endfunction

  // Applies one command and returns the status the block reports for it.
  function automatic out_t motor_status(in_t c);
    out_t r;
    bit pulse;
    pulse = 1'b0;
    case (func_t'(c.func))
      FUNC_TICK:    pulse = motor_tick(c.home_sensor);
      FUNC_MOVE:    launch(c.move_steps, c.top_speed, c.ramp_interval);
      FUNC_MOVE_MM: launch(int'(longint'(c.target_mm) * longint'(m_spmm) - longint'(m_pos)),
                           c.top_speed, c.ramp_interval);
      FUNC_HOME: begin
        m_homing = 1'b1;
        launch(int'(-1000 * longint'(m_sprev)), c.top_speed, c.ramp_interval);
      end
      FUNC_STOP:    halt_motor();
      FUNC_RUN: begin
        m_cont = 1'b1;
        launch(int'((c.run_forward ? 100 : -100) * longint'(m_sprev)),
               c.top_speed, c.ramp_interval);
      end
      FUNC_LOAD:    m_curve[c.curve_index] = c.curve_value;
      default: ;
    endcase
    r.step_pulse   = pulse;
    r.dir_level    = m_dir[0];
    r.abs_position = m_pos;
    r.phase        = m_phase[1:0];
    return r;
  endfunction

  function automatic void model_reset();
    m_thr = 10000; m_spmm = 100; m_sprev = 3200; m_home_lvl = 0; m_home_dir = 0;
    m_phase = 0; m_goal = 0; m_done = 0; m_pos = 0; m_speed = 0; m_peak = 0;
    m_accum = 0; m_ticks = 0; m_ivl = 0; m_cpos = 0; m_ramp_steps = 0;
    m_ramp_on = 0; m_homing = 0; m_cont = 0; m_dir = 0;
  endfunction

  // ---------------------------------------------------------------
  // Driver: new transfer on the falling edge once the last one was taken.
  // ---------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || took) begin
        if (cmd_q.size() > 0 && !(idle_mode[0] && $urandom_range(99) < idle_pct)) begin
          in_valid <= 1'b1;
          in_data  <= cmd_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= idle_mode[1] && ($urandom_range(99) < idle_pct);
    end
    took <= 1'b0;
  end

  // Accepted command: predict its status right away.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      status_q.push_back(motor_status(in_data));
      took <= 1'b1;
    end
  end

  // Monitor: every accepted status against the oldest prediction.
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (status_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected status transfer: %p", out_data);
      end else begin
        want = status_q.pop_front();
        if (out_data.step_pulse !== want.step_pulse || out_data.dir_level !== want.dir_level ||
            out_data.abs_position !== want.abs_position || out_data.phase !== want.phase) begin
          mismatches++;
          if (mismatches <= 10)
            $display("status mismatch: expected %p, got %p", want, out_data);
        end
      end
    end
  end

  // ---------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------
  function automatic in_t rand_cmd();
    in_t c;
    logic [127:0] raw;
    int unsigned pick;
    raw = {$urandom(), $urandom(), $urandom(), $urandom()};
    c = raw[$bits(in_t)-1:0];
    pick = $urandom_range(99);
    if (pick < 72)      c.func = FUNC_TICK;
    else if (pick < 79) c.func = FUNC_MOVE;
    else if (pick < 82) c.func = FUNC_MOVE_MM;
    else if (pick < 84) c.func = FUNC_HOME;
    else if (pick < 87) c.func = FUNC_STOP;
    else if (pick < 90) c.func = FUNC_RUN;
    else if (pick < 97) c.func = FUNC_LOAD;
    else                c.func = FUNC_NOP;
    // short moves and quick ramps so runs reach cruise and decel
    if ($urandom_range(9) < 8) begin
      c.move_steps = $urandom_range(60, 1);
      if ($urandom_range(1)) c.move_steps = -c.move_steps;
    end
    if ($urandom_range(9) < 8) c.ramp_interval = 16'($urandom_range(3));
    if ($urandom_range(9) < 7) c.target_mm = 16'($urandom_range(3));
    // home switch mostly inactive so runs toward home can progress
    if ($urandom_range(9) < 8) c.home_sensor = ~m_home_lvl[0];
    return c;
  endfunction

  function automatic in_t mk(func_t f, int steps, logic [15:0] top, logic [15:0] ivl);
    in_t c;
    c = '0;
    c.func = f;
    c.move_steps = steps;
    c.top_speed = top;
    c.ramp_interval = ivl;
    return c;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_ACCUM_THR:  m_thr = val;
      CFG_STEPS_MM:   m_spmm = val & 16'h7FFF;
      CFG_STEPS_REV:  m_sprev = val;
      CFG_HOME_LEVEL: m_home_lvl = val & 1;
      CFG_HOME_DIR:   m_home_dir = val & 1;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (cmd_q.size() > 0 || in_valid || status_q.size() > 0) @(posedge clk);
    // a curve step can keep the block busy while the table read and multiply finish
    repeat (8) @(posedge clk);
  endtask

  logic [15:0] thr_set[NUM_PASSES]   = '{10000, 1, 65535, 500, 2000, 30000};
  logic [15:0] spmm_set[NUM_PASSES]  = '{100, 1, 32767, 7, 32767, 3};
  logic [15:0] sprev_set[NUM_PASSES] = '{3200, 1, 65535, 20, 1, 65535};
  logic        lvl_set[NUM_PASSES]   = '{0, 1, 0, 1, 1, 0};
  logic        hdir_set[NUM_PASSES]  = '{0, 1, 1, 0, 1, 0};

  initial begin
    in_t c;
    model_reset();
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    for (int p = 0; p < NUM_PASSES; p++) begin
      idle_mode = p % 4;
      idle_pct  = (idle_mode == 3) ? 26 : 59;
      write_reg(CFG_ACCUM_THR, thr_set[p]);
      write_reg(CFG_STEPS_MM, spmm_set[p]);
      write_reg(CFG_STEPS_REV, sprev_set[p]);
      write_reg(CFG_HOME_LEVEL, lvl_set[p]);
      write_reg(CFG_HOME_DIR, hdir_set[p]);
      if (p == 0) begin
        // fill the whole curve table first, so no run reads an unloaded entry
        for (int i = 0; i < TABLE_SIZE; i++) begin
          c = mk(FUNC_LOAD, 0, 0, 0);
          c.curve_index = 8'(i);
          c.curve_value = (i == 0) ? 16'h0000 : (i == 255) ? 16'hFFFF : 16'(i * 256 + 255);
          cmd_q.push_back(c);
        end
        // directed: extremes, every command, zero move, no-op code
        cmd_q.push_back(mk(FUNC_TICK, 0, 0, 0));
        cmd_q.push_back(mk(FUNC_MOVE, 0, 16'hFFFF, 0));
        cmd_q.push_back(mk(FUNC_MOVE, 32'sh7FFFFFFF, 16'hFFFF, 16'hFFFF));
        cmd_q.push_back(mk(FUNC_TICK, 0, 0, 0));
        cmd_q.push_back(mk(FUNC_MOVE, 32'sh80000000, 0, 0));
        for (int i = 0; i < 4; i++) cmd_q.push_back(mk(FUNC_TICK, 0, 0, 0));
        cmd_q.push_back(mk(FUNC_MOVE, 3, 16'd9950, 0));
        for (int i = 0; i < 6; i++) cmd_q.push_back(mk(FUNC_TICK, 0, 0, 0));
        c = mk(FUNC_MOVE_MM, 0, 16'hFFFF, 1);
        c.target_mm = 16'hFFFF;
        cmd_q.push_back(c);
        cmd_q.push_back(mk(FUNC_STOP, 0, 0, 0));
        cmd_q.push_back(mk(FUNC_HOME, 0, 16'hFFFF, 0));
        c = mk(FUNC_TICK, 0, 0, 0);
        c.home_sensor = 1'b0;
        cmd_q.push_back(c);
        c = mk(FUNC_RUN, 0, 16'd500, 0);
        c.run_forward = 1'b1;
        cmd_q.push_back(c);
        cmd_q.push_back(mk(FUNC_NOP, -1, 16'hFFFF, 16'hFFFF));
        cmd_q.push_back(mk(FUNC_STOP, 0, 0, 0));
      end
      for (int i = 0; i < 190; i++) cmd_q.push_back(rand_cmd());
      drain();
    end

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/sscp_pkg.sv
rtl/sscp_curve_lut.sv
rtl/stepper_s_curve_profile_top.sv
dv/testbench.sv
